// ===== hw/rtl/spq_pkg.sv =====
// Shared constants, codes and the control bundle for the sorted priority queue.
package spq_pkg;

  // Storage depth and derived widths.
  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  // Operation codes.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } ctl_t;

endpackage

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: a chain of cells plus an output register.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   input    | in_valid / in_stall    | opcode, value_in
//   output   | out_valid / out_stall  | status, count, value_out
//
// In each transaction every cell compares and shifts in parallel,
// and the result lands in the output register on the accepting edge.
// A new transaction is taken every cycle while the output register is free or drained.
// Reset clears the entry count and the output valid; stored entries need no clearing.
// While out_stall holds a waiting result, in_stall is raised and the queue holds.
module sorted_priority_queue_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic signed [spq_pkg::DATA_W-1:0] value_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [spq_pkg::COUNT_W-1:0]       count,
  output logic signed [spq_pkg::DATA_W-1:0] value_out
);

  localparam logic [spq_pkg::CNT_W-1:0] FULL_CNT = spq_pkg::CNT_W'(spq_pkg::DEPTH);

  logic                        accept;
  logic                        is_full;
  logic                        is_empty;
  logic [spq_pkg::CNT_W-1:0]   cnt;
  logic [spq_pkg::CNT_W-1:0]   cnt_next;
  logic [1:0]                  status_next;
  logic signed [spq_pkg::DATA_W-1:0] value_next;
  spq_pkg::ctl_t               ctl;

  logic                              after_w [spq_pkg::DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] entry_w [spq_pkg::DEPTH];

  // Input handshake: hold off only while a finished result is still stalled.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (cnt == FULL_CNT);
  assign is_empty = (cnt == '0);

  // Control broadcast to the cells.
  assign ctl.enq   = accept && (opcode == spq_pkg::OP_ENQ) && !is_full;
  assign ctl.deq   = accept && (opcode == spq_pkg::OP_DEQ) && !is_empty;
  assign ctl.value = value_in;
  assign ctl.count = cnt;

  // Chain of cells; the first has nothing to its left, the last keeps itself.
  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    logic                              left_after;
    logic signed [spq_pkg::DATA_W-1:0] left_entry;
    logic signed [spq_pkg::DATA_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_after = 1'b0;
      assign left_entry = value_in;
    end else begin : g_mid
      assign left_after = after_w[i-1];
      assign left_entry = entry_w[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_inner
      assign right_entry = entry_w[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (spq_pkg::CNT_W'(i)),
      .left_after  (left_after),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .after       (after_w[i]),
      .entry       (entry_w[i])
    );
  end

  // Result of the current transaction.
  always_comb begin
    cnt_next    = cnt;
    status_next = spq_pkg::ST_OK;
    value_next  = '0;
    if (opcode == spq_pkg::OP_ENQ) begin
      if (is_full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        cnt_next   = cnt - 1'b1;
        value_next = entry_w[0];
      end
    end
  end

  // Entry count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      count     <= spq_pkg::COUNT_W'(cnt_next);
      value_out <= value_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_CNT)
    else $error("entry count exceeds depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == spq_pkg::ST_FULL) |-> (count == spq_pkg::COUNT_W'(spq_pkg::DEPTH)))
    else $error("full status with queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == spq_pkg::ST_EMPTY) |-> (count == '0 && value_out == '0))
    else $error("empty status with nonzero count or value");
`endif

endmodule

// ===== hw/rtl/spq_cell.sv =====
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::ctl_t                     ctl,
  input  logic [spq_pkg::CNT_W-1:0]         idx,
  input  logic                              left_after,
  input  logic signed [spq_pkg::DATA_W-1:0] left_entry,
  input  logic signed [spq_pkg::DATA_W-1:0] right_entry,
  output logic                              after,
  output logic signed [spq_pkg::DATA_W-1:0] entry
);

  logic occupied;
  logic signed [spq_pkg::DATA_W-1:0] entry_next;

  // The cell lies at or past the insert point when it is free or holds a
  // strictly greater entry; stored order keeps this flag monotone.
  assign occupied = (idx < ctl.count);
  assign after    = !occupied || (ctl.value < entry);

  // Insert shifts the tail up by one; dequeue pulls everything down by one.
  always_comb begin
    entry_next = entry;
    if (ctl.enq) begin
      if (left_after) begin
        entry_next = left_entry;
      end else if (after) begin
        entry_next = ctl.value;
      end
    end else if (ctl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
